### design/mdioc45_pkg.sv
// Shared types and constants for the Clause 45 PHY identification probe.
package mdioc45_pkg;

    localparam int MAX_DEVICES_DEF = 8;

    localparam int PORT_W  = 5;
    localparam int MMD_W   = 3;
    localparam int REG_W   = 3;
    localparam int VALUE_W = 32;
    localparam int HALF_W  = 16;

    localparam logic [VALUE_W-1:0] NO_DIP_MASK = 32'h1fff_ffff;

    localparam logic [REG_W-1:0] REG_ID_HIGH  = 3'd2;
    localparam logic [REG_W-1:0] REG_ID_LOW   = 3'd3;
    localparam logic [REG_W-1:0] REG_DIP_LOW  = 3'd5;
    localparam logic [REG_W-1:0] REG_DIP_HIGH = 3'd6;

    // Result queue sizing: one accepted word can push two results.
    localparam int RES_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_REQ  = 2'd0,
        KIND_ID   = 2'd1,
        KIND_DONE = 2'd2,
        KIND_FAIL = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_DIP_HIGH = 4'b0001,
        PH_DIP_LOW  = 4'b0010,
        PH_ID_HIGH  = 4'b0100,
        PH_ID_LOW   = 4'b1000
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        logic [PORT_W-1:0]   port_address;
        logic [MMD_W-1:0]    mmd_device;
        logic [REG_W-1:0]    mmd_register;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } result_t;

    // Write side of the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_push_t;

endpackage

### design/mdioc45_res_fifo.sv
// Small result queue that takes up to two results per cycle and emits one.
module mdioc45_res_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mdioc45_pkg::res_push_t push,
    output logic                 room_two,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output mdioc45_pkg::result_t rd_data
);

    localparam int DEPTH = mdioc45_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mdioc45_pkg::result_t entries_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign pop          = rd_valid && rd_ready;
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = entries_reg[rd_ptr_reg];
    assign room_two     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/mdio_c45_device_id_probe_top.sv
// Top level of the Clause 45 PHY identification probe sequencer.
//
// Usage: the s_ channel carries commands and MDIO read responses. A word with
// func = 0 starts (or restarts) a probe; a word with func = 1 delivers the
// result of the last requested read. The m_ channel carries the results: read
// requests for the MDIO controller, device id reports, and a final complete
// or failed word. m_tlast marks the last result caused by one input word.
// The cfg channel sets the PHY port address copied into every request; it is
// always ready and should be written while no probe is in flight.
//
// Results are pushed into the result queue when their input word is taken.
// One input word per cycle is taken while s_tready is high. A word that ends
// an id read causes two results, so the output side sets the pace for it.
// s_tready stays high while the four-entry result queue has room for two
// results; when the receiver stalls, the queue fills and s_tready drops.
// Reset (aresetn low, synchronous) empties the queue, returns the sequencer
// to idle and clears the port address to zero. Responses seen while idle
// are dropped without a result.
module mdio_c45_device_id_probe_top #(
    parameter int MAX_DEVICES = mdioc45_pkg::MAX_DEVICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] read_data
    input  logic [1:0]  s_tuser,  // [0] func, [1] read_error
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // [4:0] port_address, [7:5] mmd_device,
                                  // [10:8] mmd_register, [42:11] value, rest 0
    output logic [1:0]  m_tuser,  // [1:0] kind
    output logic        m_tlast,
    // Configuration.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data  // phy_address
);

    localparam int DEV_W  = $clog2(MAX_DEVICES);
    localparam int FROM_W = DEV_W + 1;
    localparam int PACK_W = mdioc45_pkg::PORT_W + mdioc45_pkg::MMD_W
                          + mdioc45_pkg::REG_W + mdioc45_pkg::VALUE_W;
    localparam int PAD_W  = 48 - PACK_W;

    logic [mdioc45_pkg::PORT_W-1:0]      port_reg, port_next;
    logic                                running_reg, running_next;
    mdioc45_pkg::phase_t                 phase_reg, phase_next;
    logic [DEV_W-1:0]                    cur_dev_reg, cur_dev_next;
    logic                                fallback_reg, fallback_next;
    logic [mdioc45_pkg::VALUE_W-1:0]     mask_reg, mask_next;
    logic [mdioc45_pkg::HALF_W-1:0]      upper_reg, upper_next;

    logic                                accept;
    logic                                in_func;
    logic                                in_error;
    logic [mdioc45_pkg::HALF_W-1:0]      in_data;
    logic [mdioc45_pkg::VALUE_W-1:0]     word;

    logic [mdioc45_pkg::VALUE_W-1:0]     search_mask;
    logic [FROM_W-1:0]                   search_from;
    logic                                search_hit;
    logic [DEV_W-1:0]                    search_idx;
    logic [FROM_W-1:0]                   cur_plus1;

    mdioc45_pkg::res_push_t              push;
    logic                                room_two;
    mdioc45_pkg::result_t                out_res;

    function automatic logic [mdioc45_pkg::MMD_W-1:0] dev_bits(input logic [DEV_W-1:0] d);
        logic [31:0] wide;
        wide = 32'(d);
        return wide[mdioc45_pkg::MMD_W-1:0];
    endfunction

    function automatic mdioc45_pkg::result_t make_res(
        input mdioc45_pkg::kind_t               kind,
        input logic [mdioc45_pkg::PORT_W-1:0]   port,
        input logic [mdioc45_pkg::MMD_W-1:0]    dev,
        input logic [mdioc45_pkg::REG_W-1:0]    regn,
        input logic [mdioc45_pkg::VALUE_W-1:0]  value,
        input logic                             last
    );
        mdioc45_pkg::result_t r;
        r.kind         = kind;
        r.port_address = port;
        r.mmd_device   = dev;
        r.mmd_register = regn;
        r.value        = value;
        r.last         = last;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = room_two;
    assign accept    = s_tvalid && s_tready;
    assign in_func   = s_tuser[0];
    assign in_error  = s_tuser[1];
    assign in_data   = s_tdata;
    assign word      = {upper_reg, in_data};
    assign cur_plus1 = {1'b0, cur_dev_reg} + FROM_W'(1);

    // The id scan looks at the fresh word after the devices-in-package read,
    // and at the stored word after each id report.
    always_comb begin
        if (phase_reg == mdioc45_pkg::PH_DIP_LOW) begin
            search_mask = word;
            search_from = FROM_W'(1);
        end else begin
            search_mask = mask_reg;
            search_from = cur_plus1;
        end
        search_hit = 1'b0;
        search_idx = '0;
        for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
            if (search_mask[i] && (FROM_W'(i) >= search_from)) begin
                search_hit = 1'b1;
                search_idx = DEV_W'(i);
            end
        end
    end

    always_comb begin
        mdioc45_pkg::result_t next_res;

        port_next     = port_reg;
        running_next  = running_reg;
        phase_next    = phase_reg;
        cur_dev_next  = cur_dev_reg;
        fallback_next = fallback_reg;
        mask_next     = mask_reg;
        upper_next    = upper_reg;
        push.count    = 2'd0;
        push.first    = '0;
        push.second   = '0;

        // Outcome of the id scan: the next id request, or completion.
        if (search_hit) begin
            next_res = make_res(mdioc45_pkg::KIND_REQ, port_reg, dev_bits(search_idx),
                                mdioc45_pkg::REG_ID_HIGH, '0, 1'b1);
        end else begin
            next_res = make_res(mdioc45_pkg::KIND_DONE, '0, '0, '0, search_mask, 1'b1);
        end

        if (cfg_valid && cfg_ready) begin
            port_next = cfg_data;
        end

        if (accept) begin
            if (!in_func) begin
                running_next  = 1'b1;
                phase_next    = mdioc45_pkg::PH_DIP_HIGH;
                cur_dev_next  = DEV_W'(1);
                fallback_next = 1'b0;
                mask_next     = '0;
                upper_next    = '0;
                push.count    = 2'd1;
                push.first    = make_res(mdioc45_pkg::KIND_REQ, port_reg, 3'd1,
                                         mdioc45_pkg::REG_DIP_HIGH, '0, 1'b1);
            end else if (running_reg) begin
                push.count = 2'd1;
                if (in_error) begin
                    running_next = 1'b0;
                    phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                    push.first   = make_res(mdioc45_pkg::KIND_FAIL, '0, '0, '0, '0, 1'b1);
                end else begin
                    unique case (phase_reg)
                        mdioc45_pkg::PH_DIP_HIGH: begin
                            upper_next = in_data;
                            phase_next = mdioc45_pkg::PH_DIP_LOW;
                            push.first = make_res(mdioc45_pkg::KIND_REQ, port_reg,
                                                  dev_bits(cur_dev_reg),
                                                  mdioc45_pkg::REG_DIP_LOW, '0, 1'b1);
                        end
                        mdioc45_pkg::PH_DIP_LOW: begin
                            mask_next = word;
                            if ((word & mdioc45_pkg::NO_DIP_MASK) == mdioc45_pkg::NO_DIP_MASK)
                            begin
                                if (fallback_reg) begin
                                    running_next = 1'b0;
                                    phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                                    push.first   = make_res(mdioc45_pkg::KIND_FAIL,
                                                            '0, '0, '0, '0, 1'b1);
                                end else begin
                                    // Retry the devices-in-package word from MMD 0.
                                    fallback_next = 1'b1;
                                    cur_dev_next  = '0;
                                    phase_next    = mdioc45_pkg::PH_DIP_HIGH;
                                    push.first    = make_res(mdioc45_pkg::KIND_REQ, port_reg,
                                                             '0, mdioc45_pkg::REG_DIP_HIGH,
                                                             '0, 1'b1);
                                end
                            end else if ((word == '0) && !fallback_reg &&
                                         (cur_plus1 < FROM_W'(MAX_DEVICES))) begin
                                cur_dev_next = cur_plus1[DEV_W-1:0];
                                phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                                push.first   = make_res(mdioc45_pkg::KIND_REQ, port_reg,
                                                        dev_bits(cur_plus1[DEV_W-1:0]),
                                                        mdioc45_pkg::REG_DIP_HIGH, '0, 1'b1);
                            end else begin
                                push.first = next_res;
                                if (search_hit) begin
                                    cur_dev_next = search_idx;
                                    phase_next   = mdioc45_pkg::PH_ID_HIGH;
                                end else begin
                                    running_next = 1'b0;
                                    phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                                end
                            end
                        end
                        mdioc45_pkg::PH_ID_HIGH: begin
                            upper_next = in_data;
                            phase_next = mdioc45_pkg::PH_ID_LOW;
                            push.first = make_res(mdioc45_pkg::KIND_REQ, port_reg,
                                                  dev_bits(cur_dev_reg),
                                                  mdioc45_pkg::REG_ID_LOW, '0, 1'b1);
                        end
                        mdioc45_pkg::PH_ID_LOW: begin
                            push.count  = 2'd2;
                            push.first  = make_res(mdioc45_pkg::KIND_ID, '0,
                                                   dev_bits(cur_dev_reg), '0, word, 1'b0);
                            push.second = next_res;
                            if (search_hit) begin
                                cur_dev_next = search_idx;
                                phase_next   = mdioc45_pkg::PH_ID_HIGH;
                            end else begin
                                running_next = 1'b0;
                                phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                            end
                        end
                        default: begin
                            running_next = 1'b0;
                            phase_next   = mdioc45_pkg::PH_DIP_HIGH;
                            push.first   = make_res(mdioc45_pkg::KIND_FAIL,
                                                    '0, '0, '0, '0, 1'b1);
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg     <= '0;
            running_reg  <= 1'b0;
            phase_reg    <= mdioc45_pkg::PH_DIP_HIGH;
            cur_dev_reg  <= '0;
            fallback_reg <= 1'b0;
            mask_reg     <= '0;
            upper_reg    <= '0;
        end else begin
            port_reg     <= port_next;
            running_reg  <= running_next;
            phase_reg    <= phase_next;
            cur_dev_reg  <= cur_dev_next;
            fallback_reg <= fallback_next;
            mask_reg     <= mask_next;
            upper_reg    <= upper_next;
        end
    end

    mdioc45_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room_two (room_two),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_res.value, out_res.mmd_register,
                      out_res.mmd_device, out_res.port_address};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
